[design/skq_pkg.sv]
// ----------------------------------------------------------------------------
// skq_pkg: shared types and codes of the sorted key queue
// Item and result structs, action and status codes, cell command types.
// ----------------------------------------------------------------------------
package skq_pkg;

  localparam int KeyW = 32;
  localparam int PayW = 32;
  localparam int CntOutW = 5;

  localparam logic [2:0] ACT_PREPEND  = 3'd0;
  localparam logic [2:0] ACT_APPEND   = 3'd1;
  localparam logic [2:0] ACT_SORTED   = 3'd2;
  localparam logic [2:0] ACT_REM_HEAD = 3'd3;
  localparam logic [2:0] ACT_REM_KEY  = 3'd4;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [2:0]             action;
    logic [PayW-1:0]        payload_in;
    logic signed [KeyW-1:0] search_key;
  } skq_in_t;

  typedef struct packed {
    logic [1:0]             status;
    logic [PayW-1:0]        payload_out;
    logic signed [KeyW-1:0] key_out;
    logic [CntOutW-1:0]     entry_count;
  } skq_out_t;

  // how a cell decides it is the target position
  typedef enum logic [1:0] {
    MODE_FIRST,    // head slot
    MODE_FREE,     // first empty slot
    MODE_GREATER,  // first slot with key above the search key, or empty
    MODE_EQUAL     // first occupied slot with key equal to the search key
  } mode_e;

  typedef struct packed {
    logic signed [KeyW-1:0] key;
    logic [PayW-1:0]        payload;
  } ent_t;

  typedef struct packed {
    mode_e                  mode;
    logic                   tap_tail;
    logic                   ins;
    logic                   rem;
    logic signed [KeyW-1:0] search_key;
  } cell_cmd_t;

  // carried from cell to cell: target already found, tapped entry
  typedef struct packed {
    logic found;
    ent_t tap;
  } link_t;

endpackage

[design/sorted_key_queue.sv]
// ----------------------------------------------------------------------------
// sorted_key_queue: bounded queue of (key, payload) entries in key order
// A row of DEPTH slot cells with a shared entry count.
// ----------------------------------------------------------------------------
// Usage:
//   Drive item_i and raise start; the command transfers on a clock edge
//   with start high and busy low. busy stays low, so a command can be
//   issued in every cycle.
//   One result per command appears on result_o in the next cycle, marked by
//   result_valid_o for exactly one cycle; the receiver cannot stall it.
//   Throughput 1 command per cycle. Every slot compares against the search
//   key in parallel; the target slot is found by a ripple through the cell
//   row, and the row shifts in the same edge.
//   Actions: prepend, append, sorted insert, remove head, remove by key.
//   Status reports done, empty or key not found, or queue full.
//   Reset (rst_ni low) empties the queue and drops any pending result;
//   slot contents are not cleared and are never read while empty.
// ----------------------------------------------------------------------------
module sorted_key_queue #(
  parameter int DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  skq_pkg::skq_in_t  item_i,
  output logic              result_valid_o,
  output skq_pkg::skq_out_t result_o
);
  import skq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DepthC = CW'(DEPTH);

  logic [CW-1:0] count_q, count_d;
  logic          valid_q;
  skq_out_t      res_q, res_d;

  cell_cmd_t     cmd;
  link_t         links [DEPTH+1];
  ent_t          ents  [DEPTH];
  ent_t          new_ent;

  logic accept, is_ins, is_rem, full, empty, ins_ok, rem_ok;
  logic [CW+CntOutW-1:0] count_ext;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = count_q == DepthC;
  assign empty  = count_q == '0;

  // cells shift only where the target was found, so rem needs no found term
  always_comb begin
    is_ins       = 1'b0;
    is_rem       = 1'b0;
    cmd.mode     = MODE_FIRST;
    cmd.tap_tail = 1'b0;
    unique case (item_i.action)
      ACT_PREPEND: begin
        is_ins = 1'b1;
      end
      ACT_APPEND: begin
        is_ins       = 1'b1;
        cmd.mode     = MODE_FREE;
        cmd.tap_tail = 1'b1;
      end
      ACT_SORTED: begin
        is_ins   = 1'b1;
        cmd.mode = MODE_GREATER;
      end
      ACT_REM_HEAD: begin
        is_rem = 1'b1;
      end
      ACT_REM_KEY: begin
        is_rem   = 1'b1;
        cmd.mode = MODE_EQUAL;
      end
      default: begin
        is_ins = 1'b0;
      end
    endcase
    cmd.ins        = accept && is_ins && !full;
    cmd.rem        = accept && is_rem && !empty;
    cmd.search_key = item_i.search_key;
  end

  assign ins_ok = is_ins && !full;
  assign rem_ok = is_rem && !empty && links[DEPTH].found;

  // tapped entry: head for prepend, tail for append, target for removal
  always_comb begin
    new_ent.payload = item_i.payload_in;
    priority if (item_i.action == ACT_PREPEND) begin
      new_ent.key = empty ? '0 : links[DEPTH].tap.key - 32'sd1;
    end else if (item_i.action == ACT_APPEND) begin
      new_ent.key = empty ? 32'sd1 : links[DEPTH].tap.key + 32'sd1;
    end else begin
      new_ent.key = item_i.search_key;
    end
  end

  assign links[0] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    ent_t left_ent, right_ent;
    if (i == 0) begin : g_first
      assign left_ent = '0;
    end else begin : g_mid_l
      assign left_ent = ents[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_ent = '0;
    end else begin : g_mid_r
      assign right_ent = ents[i+1];
    end
    skq_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .count_i (count_q),
      .new_i   (new_ent),
      .left_i  (left_ent),
      .right_i (right_ent),
      .link_i  (links[i]),
      .link_o  (links[i+1]),
      .ent_o   (ents[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (cmd.ins) begin
      count_d = count_q + CW'(1);
    end else if (accept && rem_ok) begin
      count_d = count_q - CW'(1);
    end
  end

  assign count_ext = {{CntOutW{1'b0}}, count_d};

  always_comb begin
    res_d.status      = ST_DONE;
    res_d.payload_out = '0;
    res_d.key_out     = '0;
    res_d.entry_count = count_ext[CntOutW-1:0];
    if (ins_ok) begin
      res_d.payload_out = new_ent.payload;
      res_d.key_out     = new_ent.key;
    end else if (is_ins) begin
      res_d.status = ST_FULL;
    end else if (rem_ok) begin
      res_d.payload_out = links[DEPTH].tap.payload;
      res_d.key_out     = links[DEPTH].tap.key;
    end else if (is_rem) begin
      res_d.status = ST_MISS;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign result_valid_o = valid_q;
  assign result_o       = res_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthC)
    else $error("entry count above depth");

  a_ins_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_ins && !full) |=> (count_q == $past(count_q) + CW'(1)))
    else $error("insert did not grow the queue");

  a_miss_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_rem && !rem_ok) |=> $stable(count_q))
    else $error("failed removal changed the count");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> result_valid_o)
    else $error("command without result");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_ins && full) |=> (result_o.status == ST_FULL && $stable(count_q)))
    else $error("insert into full queue not refused");

endmodule

[design/skq_cell.sv]
// ----------------------------------------------------------------------------
// skq_cell: one slot of the sorted key queue
// Holds one entry, finds the target slot with its neighbors and shifts
// left or right on insert and remove.
// ----------------------------------------------------------------------------
module skq_cell #(
  parameter int IDX = 0,
  parameter int CW  = 5
) (
  input  logic               clk_i,
  input  skq_pkg::cell_cmd_t cmd_i,
  input  logic [CW-1:0]      count_i,
  input  skq_pkg::ent_t      new_i,
  input  skq_pkg::ent_t      left_i,
  input  skq_pkg::ent_t      right_i,
  input  skq_pkg::link_t     link_i,
  output skq_pkg::link_t     link_o,
  output skq_pkg::ent_t      ent_o
);
  import skq_pkg::*;

  localparam logic [CW-1:0] IdxC  = CW'(IDX);
  localparam logic [CW-1:0] NextC = CW'(IDX + 1);

  ent_t ent_q, ent_d;
  logic occ, occ_next, hit, first, found, tap;

  assign occ      = IdxC < count_i;
  assign occ_next = NextC < count_i;

  always_comb begin
    unique case (cmd_i.mode)
      MODE_FIRST:   hit = 1'b1;
      MODE_FREE:    hit = !occ;
      MODE_GREATER: hit = !occ || (cmd_i.search_key < ent_q.key);
      MODE_EQUAL:   hit = occ && (ent_q.key == cmd_i.search_key);
      default:      hit = 1'b0;
    endcase
  end

  assign first = hit && !link_i.found;
  assign found = link_i.found || hit;
  assign tap   = cmd_i.tap_tail ? (occ && !occ_next) : (first && occ);

  assign link_o.found = found;
  assign link_o.tap   = link_i.tap | (tap ? ent_q : '0);

  always_comb begin
    ent_d = ent_q;
    if (cmd_i.ins && found) begin
      ent_d = first ? new_i : left_i;
    end else if (cmd_i.rem && found) begin
      ent_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign ent_o = ent_q;

endmodule

[tb/sorted_key_queue_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_key_queue_test: self-checking bench for the sorted key queue
// A shadow copy of the queue predicts every result. Directed commands cover
// the empty, full, wrap and unused-code cases. Random segments then push the
// queue toward full or toward empty, most with random gaps between commands.
// ----------------------------------------------------------------------------
module sorted_key_queue_test;
  import skq_pkg::*;

  localparam int QDEPTH = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 800;

  logic     clk_i = 1'b0;
  logic     rst_ni;
  logic     start;
  logic     busy;
  skq_in_t  item_i;
  logic     result_valid_o;
  skq_out_t result_o;
  int       cycles;

  // Shadow of the queue contents plus the results still owed by the block.
  class sorted_queue_shadow;
    logic signed [KeyW-1:0] keys [QDEPTH];
    logic [PayW-1:0]        payloads [QDEPTH];
    int                     fill;
    skq_out_t               awaited[$];
    int                     mismatches;

    function new();
      fill = 0;
      mismatches = 0;
    endfunction

    function void apply_command(skq_in_t cmd);
      skq_out_t               exp;
      int                     pos;
      logic signed [KeyW-1:0] key;
      exp = '0;
      exp.status = ST_DONE;
      case (cmd.action)
        ACT_PREPEND, ACT_APPEND, ACT_SORTED: begin
          if (fill >= QDEPTH) begin
            exp.status = ST_FULL;
          end else begin
            if (cmd.action == ACT_PREPEND) begin
              key = (fill == 0) ? 0 : keys[0] - 1;
              pos = 0;
            end else if (cmd.action == ACT_APPEND) begin
              key = (fill == 0) ? 1 : keys[fill-1] + 1;
              pos = fill;
            end else begin
              // lands after every entry whose key is <= the search key
              key = cmd.search_key;
              pos = 0;
              while (pos < fill && !(cmd.search_key < keys[pos])) pos++;
            end
            for (int i = fill; i > pos; i--) begin
              keys[i] = keys[i-1];
              payloads[i] = payloads[i-1];
            end
            keys[pos] = key;
            payloads[pos] = cmd.payload_in;
            fill++;
            exp.payload_out = cmd.payload_in;
            exp.key_out = key;
          end
        end
        ACT_REM_HEAD, ACT_REM_KEY: begin
          pos = 0;
          if (cmd.action == ACT_REM_KEY) begin
            while (pos < fill && keys[pos] != cmd.search_key) pos++;
          end
          if (pos >= fill) begin
            exp.status = ST_MISS;
          end else begin
            exp.payload_out = payloads[pos];
            exp.key_out = keys[pos];
            for (int i = pos; i + 1 < fill; i++) begin
              keys[i] = keys[i+1];
              payloads[i] = payloads[i+1];
            end
            fill--;
          end
        end
        default: ;
      endcase
      exp.entry_count = CntOutW'(fill);
      awaited.push_back(exp);
    endfunction

    function void compare_result(skq_out_t got);
      skq_out_t exp;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        mismatches++;
        return;
      end
      exp = awaited.pop_front();
      if (got.status !== exp.status) begin
        $display("%0t: status expected %0d actual %0d", $time, exp.status, got.status);
        mismatches++;
      end
      if (got.payload_out !== exp.payload_out) begin
        $display("%0t: payload_out expected %h actual %h", $time,
                 exp.payload_out, got.payload_out);
        mismatches++;
      end
      if (got.key_out !== exp.key_out) begin
        $display("%0t: key_out expected %h actual %h", $time, exp.key_out, got.key_out);
        mismatches++;
      end
      if (got.entry_count !== exp.entry_count) begin
        $display("%0t: entry_count expected %0d actual %0d", $time,
                 exp.entry_count, got.entry_count);
        mismatches++;
      end
    endfunction
  endclass

  sorted_queue_shadow sb = new();

  sorted_key_queue #(
    .DEPTH(QDEPTH)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .item_i        (item_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) sb.compare_result(result_o);
  end

  function automatic skq_in_t make_cmd(logic [2:0] act, logic [PayW-1:0] pay,
                                       logic signed [KeyW-1:0] k);
    skq_in_t c;
    c.action = act;
    c.payload_in = pay;
    c.search_key = k;
    return c;
  endfunction

  // Keys that hit: present entries, a narrow band for duplicates, extremes; also random keys.
  function automatic logic signed [KeyW-1:0] pick_key();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (sb.fill > 0 && r < 4) return sb.keys[$urandom_range(0, sb.fill - 1)];
    if (r < 7) return int'($urandom_range(0, 16)) - 8;
    if (r == 7) begin
      case ($urandom_range(0, 3))
        0: return {1'b1, {(KeyW-1){1'b0}}};
        1: return {1'b0, {(KeyW-1){1'b1}}};
        2: return '1;
        default: return '0;
      endcase
    end
    return $urandom();
  endfunction

  // Holds the command until the transfer, then notes it in the shadow.
  task automatic send_cmd(skq_in_t cmd, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    item_i <= cmd;
    do @(posedge clk_i); while (busy);
    sb.apply_command(cmd);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk_i);
  endtask

  // Returns how many commands sent were not unused codes.
  task automatic run_segment(int n, bit fill_bias, bit no_idle, output int useful);
    int unsigned r;
    int          ins_weight;
    logic [2:0]  act;
    useful = 0;
    ins_weight = fill_bias ? 70 : 30;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        act = ACT_REM_KEY + 3'($urandom_range(1, 3));
      end else if (r < 3 + ins_weight) begin
        case ($urandom_range(0, 2))
          0: act = ACT_PREPEND;
          1: act = ACT_APPEND;
          default: act = ACT_SORTED;
        endcase
        useful++;
      end else begin
        act = $urandom_range(0, 1) ? ACT_REM_HEAD : ACT_REM_KEY;
        useful++;
      end
      send_cmd(make_cmd(act, $urandom(), pick_key()), no_idle ? 0 : $urandom_range(0, 10));
    end
  endtask

  initial begin
    int sent;
    int got;
    int seg;
    rst_ni = 1'b0;
    start = 1'b0;
    item_i = '0;
    cycles = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty queue, sole entry removed by key, key wrap at both ends
    send_cmd(make_cmd(ACT_REM_HEAD, '1, 0), 0);
    send_cmd(make_cmd(ACT_REM_KEY, 0, 0), 0);
    send_cmd(make_cmd(ACT_PREPEND, 32'h1234_5678, 0), 1);
    send_cmd(make_cmd(ACT_REM_KEY, 0, 0), 0);
    send_cmd(make_cmd(ACT_APPEND, '1, '1), 2);
    send_cmd(make_cmd(ACT_PREPEND, 0, 0), 0);
    send_cmd(make_cmd(ACT_SORTED, '1, {1'b1, {(KeyW-1){1'b0}}}), 0);
    send_cmd(make_cmd(ACT_PREPEND, 32'hA5A5_A5A5, 0), 3);
    send_cmd(make_cmd(ACT_SORTED, 0, {1'b0, {(KeyW-1){1'b1}}}), 0);
    send_cmd(make_cmd(ACT_APPEND, 32'h5A5A_5A5A, 0), 0);
    send_cmd(make_cmd(ACT_SORTED, 32'hDEAD_BEEF, 1), 0);
    send_cmd(make_cmd(ACT_REM_KEY, 0, 1), 0);
    send_cmd(make_cmd(ACT_REM_KEY, 0, 12345), 4);
    for (int a = 1; a <= 3; a++) begin
      send_cmd(make_cmd(ACT_REM_KEY + 3'(a), '1, '1), 0);
    end
    send_cmd(make_cmd(ACT_REM_HEAD, 0, 0), 0);
    while (sb.fill < QDEPTH) send_cmd(make_cmd(ACT_APPEND, $urandom(), 0), 0);
    send_cmd(make_cmd(ACT_PREPEND, '1, 0), 0);
    send_cmd(make_cmd(ACT_APPEND, '1, 0), 0);
    send_cmd(make_cmd(ACT_SORTED, '1, 0), 0);
    wait_drained();

    sent = 0;
    seg = 0;
    while (sent < RANDOM_ITEMS) begin
      run_segment($urandom_range(20, 50), seg[0] == 1'b0, seg % 4 == 3, got);
      sent += got;
      seg++;
      if (seg == 8) wait_drained();
    end

    wait_drained();
    repeat (4) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
